// ----- hdl/burst_memory_with_latency_macros.svh -----
// Assertion macros for the burst memory with access latency.
// Used by burst_memory_with_latency; relies on clk and arst_n in scope.
`ifndef BURST_MEMORY_WITH_LATENCY_MACROS_SVH
`define BURST_MEMORY_WITH_LATENCY_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BMWL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmwl: assertion failed");
`define BMWL_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bmwl: assertion failed");
`else
`define BMWL_ASSERT(label, prop)
`define BMWL_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hdl/bmwl_pkg.sv -----
// Package for the burst memory with access latency: sizes, codes, strobe mask.
// No dependencies; used by bmwl_ram and burst_memory_with_latency.
package bmwl_pkg;

	localparam int WORD_COUNT = 65536;
	localparam int IDX_W      = $clog2(WORD_COUNT);
	localparam int WORD_W     = 32;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_ADDR_W-3:0] REG_ACCESS_LATENCY = 1'b0;
	localparam logic [7:0]            LATENCY_RESET      = 8'd8;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_LATENCY  = 2'd1;
	localparam logic [1:0] PH_TRANSFER = 2'd2;

	localparam logic ST_ACC = 1'b0;
	localparam logic ST_MEM = 1'b1;

	function automatic logic [WORD_W-1:0] strobe_mask(input logic [3:0] strobe);
		logic [WORD_W-1:0] m;
		m = '0;
		if (strobe[0]) m = m | 32'h0000_00FF;
		if (strobe[1]) m = m | 32'h0000_FF00;
		if (strobe[2]) m = m | 32'h00FF_0000;
		if (strobe[3]) m = m | 32'hFF00_0000;
		return m;
	endfunction

endpackage

// ----- hdl/bmwl_ram.sv -----
// Word store of the burst memory: one write port, one read port, registered read.
// Depends on bmwl_pkg for depth and word width.
module bmwl_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [bmwl_pkg::IDX_W-1:0]  waddr,
	input  logic [bmwl_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [bmwl_pkg::IDX_W-1:0]  raddr,
	output logic [bmwl_pkg::WORD_W-1:0] rdata
);

	logic [bmwl_pkg::WORD_W-1:0] mem [bmwl_pkg::WORD_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/burst_memory_with_latency.sv -----
// Burst memory with access latency: one input transfer per bus cycle, one result each,
// unless stalled. A transfer's result is registered and offered on the next cycle.
// Input stalls while the output is held, and after each beat that accesses the
// registered-read word store (a read, or a read-modify-write for a valid write).
// Reset: phase, counters, read register and output valid are cleared, access latency is
// reset to its default; the word store is not cleared and needs no clearing pass.
module burst_memory_with_latency (
	input  logic                              clk,
	input  logic                              arst_n,
	// enable[0], byte_strobe[4:1], beats_minus_one[12:5], write_beat_valid[13],
	// wrap_log2[17:14], address[49:18], write_data[81:50], zero[87:82]
	input  logic [bmwl_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tuser,   // req_type[0]
	input  logic                              s_tlast,   // write_beat_last
	input  logic                              s_tvalid,
	output logic                              s_tready,
	output logic [bmwl_pkg::OUT_TDATA_W-1:0]  m_tdata,   // read_data[31:0]
	output logic                              m_tuser,   // beat_valid[0]
	output logic                              m_tlast,   // beat_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bmwl_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [bmwl_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [bmwl_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	`include "burst_memory_with_latency_macros.svh"

	logic                          enable;
	logic                          req_type;
	logic [3:0]                    byte_strobe;
	logic [7:0]                    beats_minus_one;
	logic                          write_beat_valid;
	logic                          write_beat_last;
	logic [3:0]                    wrap_log2;
	logic [31:0]                   address;
	logic [31:0]                   write_data;

	logic [7:0]                    access_latency_q;
	logic [1:0]                    phase_q;
	logic [7:0]                    wait_count_q;
	logic [8:0]                    beat_count_q;
	logic [31:0]                   read_register_q;
	logic                          state_q;
	logic                          wr_q;
	logic [bmwl_pkg::IDX_W-1:0]    slot_q;
	logic [31:0]                   wdata_q;
	logic [31:0]                   mask_q;
	logic                          m_tvalid_q;
	logic                          m_tuser_q;
	logic                          m_tlast_q;
	logic [31:0]                   m_tdata_q;

	logic                          accept;
	logic                          cfg_write;
	logic                          in_transfer;
	logic                          write_end;
	logic                          mem_access;
	logic [8:0]                    len1;
	logic [8:0]                    beat_next;
	logic [7:0]                    wait_next;
	logic [1:0]                    phase_next;
	logic [31:0]                   widx;
	logic [bmwl_pkg::IDX_W-1:0]    slot;
	logic                          out_valid;
	logic                          out_last;
	logic [31:0]                   out_data;
	logic [31:0]                   rdata;
	logic                          ram_we;
	logic [31:0]                   merged;

	assign enable           = s_tdata[0];
	assign byte_strobe      = s_tdata[4:1];
	assign beats_minus_one  = s_tdata[12:5];
	assign write_beat_valid = s_tdata[13];
	assign wrap_log2        = s_tdata[17:14];
	assign address          = s_tdata[49:18];
	assign write_data       = s_tdata[81:50];
	assign req_type         = s_tuser;
	assign write_beat_last  = s_tlast;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[bmwl_pkg::CFG_ADDR_W-1:2] == bmwl_pkg::REG_ACCESS_LATENCY);
	assign prdata    = (paddr[bmwl_pkg::CFG_ADDR_W-1:2] == bmwl_pkg::REG_ACCESS_LATENCY) ?
		{24'd0, access_latency_q} : '0;

	assign s_tready = (state_q == bmwl_pkg::ST_ACC) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		len1        = {1'b0, beats_minus_one} + 9'd1;
		in_transfer = (phase_q == bmwl_pkg::PH_TRANSFER);
		write_end   = req_type && write_beat_valid && write_beat_last;
		mem_access  = in_transfer && (!req_type || write_beat_valid);

		if ((beat_count_q != 9'd0) && !req_type) begin
			out_valid = 1'b1;
			out_last  = (beat_count_q == len1);
			out_data  = read_register_q;
		end else if (in_transfer && req_type) begin
			out_valid = write_beat_valid;
			out_last  = write_beat_last;
			out_data  = '0;
		end else begin
			out_valid = 1'b0;
			out_last  = 1'b0;
			out_data  = '0;
		end

		widx = ({2'b00, address[31:2]} & (32'hFFFF_FFFF << wrap_log2)) | {23'd0, beat_count_q};
		slot = widx[bmwl_pkg::IDX_W-1:0];

		if (!in_transfer || write_end) begin
			beat_next = '0;
		end else if (mem_access) begin
			beat_next = beat_count_q + 9'd1;
		end else begin
			beat_next = beat_count_q;
		end

		wait_next = (phase_q == bmwl_pkg::PH_LATENCY) ? wait_count_q + 8'd1 : '0;

		if (enable && (wait_next == 8'd0) && (phase_q == bmwl_pkg::PH_IDLE)) begin
			phase_next = bmwl_pkg::PH_LATENCY;
		end else if (enable && (wait_next == access_latency_q) &&
				(phase_q == bmwl_pkg::PH_LATENCY)) begin
			phase_next = bmwl_pkg::PH_TRANSFER;
		end else if (enable && !req_type && (beat_next == len1) && in_transfer) begin
			phase_next = bmwl_pkg::PH_IDLE;
		end else if (enable && write_end && in_transfer) begin
			phase_next = bmwl_pkg::PH_IDLE;
		end else if (!enable) begin
			phase_next = bmwl_pkg::PH_IDLE;
		end else begin
			phase_next = phase_q;
		end
	end

	assign ram_we = (state_q == bmwl_pkg::ST_MEM) && wr_q;
	assign merged = (wdata_q & mask_q) | (rdata & ~mask_q);

	bmwl_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (merged),
		.re    (accept && mem_access),
		.raddr (slot),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_latency_q <= bmwl_pkg::LATENCY_RESET;
			phase_q          <= bmwl_pkg::PH_IDLE;
			wait_count_q     <= '0;
			beat_count_q     <= '0;
			read_register_q  <= '0;
			state_q          <= bmwl_pkg::ST_ACC;
			m_tvalid_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				access_latency_q <= pwdata[7:0];
			end
			if (accept) begin
				phase_q      <= phase_next;
				wait_count_q <= wait_next;
				beat_count_q <= beat_next;
				m_tvalid_q   <= 1'b1;
				if (mem_access) begin
					state_q <= bmwl_pkg::ST_MEM;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				bmwl_pkg::ST_MEM: begin
					state_q <= bmwl_pkg::ST_ACC;
					if (!wr_q) begin
						read_register_q <= rdata;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tuser_q <= out_valid;
			m_tlast_q <= out_last;
			m_tdata_q <= out_data;
			wr_q      <= req_type;
			slot_q    <= slot;
			wdata_q   <= write_data;
			mask_q    <= bmwl_pkg::strobe_mask(byte_strobe);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = m_tdata_q;

	`BMWL_ASSERT(a_no_accept_in_mem, (state_q == bmwl_pkg::ST_MEM) |-> !s_tready)
	`BMWL_ASSERT(a_mem_one_cycle, (state_q == bmwl_pkg::ST_MEM) |=> (state_q == bmwl_pkg::ST_ACC))
	`BMWL_ASSERT(a_access_enters_mem,
		(accept && mem_access) |=> (state_q == bmwl_pkg::ST_MEM))
	`BMWL_ASSERT_ALWAYS(a_reset_idle,
		!arst_n |=> ((phase_q == bmwl_pkg::PH_IDLE) && !m_tvalid_q))

endmodule
